### hw/rtl/tkhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkhm_pkg: shared types and constants
// Prime constants, lane seeds and rotation helpers for the triple key hash.
// ----------------------------------------------------------------------------
package tkhm_pkg;

    localparam int unsigned LANES = 4;
    localparam int unsigned HASH_W = 64;
    localparam int unsigned SIZE_W = 63;
    localparam int unsigned DIV_STAGES = HASH_W;

    localparam logic [31:0] HP1 = 32'h9E3779B1;
    localparam logic [31:0] HP2 = 32'h85EBCA77;
    localparam logic [31:0] HP3 = 32'hC2B2AE3D;
    localparam logic [31:0] HP4 = 32'h27D4EB2F;
    localparam logic [31:0] HP5 = 32'h165667B1;
    localparam logic [63:0] KEY_LEN = 64'd24;

    typedef logic [63:0] lane_t;
    typedef lane_t [LANES-1:0] lanes_t;

    // One split product: low half times the prime in full, high half mod 2^32.
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
    } pprod_t;
    typedef pprod_t [LANES-1:0] pprods_t;

    function automatic lane_t rotl(input lane_t x, input logic [5:0] r);
        rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    localparam lane_t SEED1 = 64'(HP5);
    localparam lane_t SEED2 = SEED1 * 64'(HP2) + KEY_LEN;
    localparam lane_t SEED3 = SEED2 * 64'(HP3);
    localparam lane_t SEED4 = SEED3 * 64'(HP4);

    localparam lane_t RSEED1 = (SEED1 << 13) | (SEED1 >> 51);
    localparam lane_t RSEED2 = (SEED2 << 11) | (SEED2 >> 53);
    localparam lane_t RSEED3 = (SEED3 << 17) | (SEED3 >> 47);
    localparam lane_t RSEED4 = (SEED4 << 19) | (SEED4 >> 45);

    localparam lane_t FIN_ADD = (64'(HP4) + KEY_LEN) * 64'(HP1);

    function automatic pprod_t pmul(input lane_t x, input logic [31:0] c);
        pprod_t p;
        p.lo = 64'(x[31:0]) * 64'(c);
        p.hi = x[63:32] * c;
        pmul = p;
    endfunction

    function automatic lane_t psum(input pprod_t p);
        psum = p.lo + {p.hi, 32'd0};
    endfunction

endpackage

### hw/rtl/tkhm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkhm_key_if / tkhm_bucket_if: stream channels
// Valid/ready channels for key beats in and bucket beats out.
// ----------------------------------------------------------------------------
interface tkhm_key_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  key_byte;
    logic signed [63:0] key_first;
    logic signed [63:0] key_second;
    logic signed [63:0] key_third;

    modport source (output valid, key_byte, key_first, key_second, key_third, input ready);
    modport sink (input valid, key_byte, key_first, key_second, key_third, output ready);
endinterface

interface tkhm_bucket_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] bucket;

    modport source (output valid, bucket, input ready);
    modport sink (input valid, bucket, output ready);
endinterface

### hw/rtl/triple_key_hash_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_key_hash_mod_unit: pipelined key hash with table-size reduction
// Hashes a byte and three 64-bit keys and reduces the hash by a table size.
// ----------------------------------------------------------------------------
// Usage notes.
// A key beat enters on key_in and one bucket beat leaves on bucket_out for
// every key beat, in order. The hash mix runs through eleven register stages,
// where each 64-bit by 32-bit prime multiply is split into two partial products
// that are summed in the following stage. The modulo by the table size is a
// restoring remainder pipeline of 64 stages, one hash bit per stage, followed
// by the output register. Throughput is one beat per cycle: the whole pipe
// advances whenever the output register is empty or being taken, so the rate
// is set only by the receiver. When bucket_out stalls with a beat held, every
// stage freezes and key_in.ready drops in the same cycle; nothing is lost or
// repeated. The user must write the table size through cfg_we/cfg_wdata only
// while the pipe is empty; the block does not enforce it. A size of zero
// makes every bucket all ones. Reset clears all valid bits and sets the table
// size to zero; payload registers are not reset.
// ----------------------------------------------------------------------------
module triple_key_hash_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tkhm_pkg::SIZE_W-1:0]  cfg_wdata,
    tkhm_key_if.sink                     key_in,
    tkhm_bucket_if.source                bucket_out
);
    import tkhm_pkg::*;

    localparam int unsigned MIX_STAGES = 11;

    logic [SIZE_W-1:0] size_reg;
    logic              adv;

    // Valid bits of the mix stages.
    logic [MIX_STAGES-1:0] mv_reg;

    // Mix stage payloads.
    lanes_t  keys1_reg, keys2_reg;
    lanes_t  s1_reg;
    pprods_t s2_reg;
    lanes_t  s3_reg;
    pprods_t s4_reg;
    lanes_t  s5_reg;
    pprods_t s6_reg;
    lanes_t  s7_reg;
    lane_t   s8_reg;
    lane_t   s9_reg;
    pprod_t  s10_reg;
    lane_t   s11_reg;

    lanes_t s1_next, s3_next, s5_next, s7_next;
    lane_t  s8_next, s9_next, s11_next, comb_h;

    // Remainder pipeline.
    logic [DIV_STAGES-1:0] dv_reg;
    lane_t                 dr_reg [DIV_STAGES];
    lane_t                 dh_reg [DIV_STAGES];
    lane_t                 divisor;

    logic               out_valid_reg;
    logic signed [63:0] bucket_reg;

    assign adv = !out_valid_reg || bucket_out.ready;
    assign key_in.ready = adv;
    assign divisor = {1'b0, size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // Stage 1: seed plus key, then the first rotate-add.
    always_comb
    begin
        lanes_t t;
        t[0] = RSEED1 + lane_t'(key_in.key_first);
        t[1] = RSEED2 + lane_t'(key_in.key_second);
        t[2] = RSEED3 + lane_t'(key_in.key_third);
        t[3] = RSEED4 + {{56{key_in.key_byte[7]}}, key_in.key_byte};
        s1_next[0] = t[0] + rotl(t[0], 6'd17);
        s1_next[1] = t[1] + rotl(t[1], 6'd19);
        s1_next[2] = t[2] + rotl(t[2], 6'd13);
        s1_next[3] = t[3] + rotl(t[3], 6'd11);
    end

    // Stage 3: finish multiply by HP1, add the three 64-bit keys again and HP5 in lane 3.
    always_comb
    begin
        s3_next[0] = psum(s2_reg[0]) + keys2_reg[0];
        s3_next[1] = psum(s2_reg[1]) + keys2_reg[1];
        s3_next[2] = psum(s2_reg[2]) + keys2_reg[2];
        s3_next[3] = psum(s2_reg[3]) + 64'(HP5);
    end

    // Stage 5: finish multiply by HP2, then the second rotate-add.
    always_comb
    begin
        lanes_t t;
        for (int i = 0; i < LANES; i++)
        begin
            t[i] = psum(s4_reg[i]);
        end
        s5_next[0] = t[0] + rotl(t[0], 6'd11);
        s5_next[1] = t[1] + rotl(t[1], 6'd17);
        s5_next[2] = t[2] + rotl(t[2], 6'd19);
        s5_next[3] = t[3] + rotl(t[3], 6'd13);
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            s7_next[i] = psum(s6_reg[i]);
        end
    end

    // Stage 8: merge the lanes, first xor-shift.
    assign comb_h = s7_reg[0] + rotl(s7_reg[1], 6'd3) + rotl(s7_reg[2], 6'd6)
                  + rotl(s7_reg[3], 6'd9);
    assign s8_next = comb_h ^ (comb_h >> 11);

    always_comb
    begin
        lane_t t;
        t = s8_reg + FIN_ADD;
        s9_next = t ^ (t >> 15);
    end

    always_comb
    begin
        lane_t t;
        t = psum(s10_reg);
        s11_next = t ^ (t >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else if (adv)
        begin
            mv_reg <= {mv_reg[MIX_STAGES-2:0], key_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            keys1_reg <= {{{56{key_in.key_byte[7]}}, key_in.key_byte},
                          lane_t'(key_in.key_third), lane_t'(key_in.key_second),
                          lane_t'(key_in.key_first)};
            keys2_reg <= keys1_reg;
            s1_reg <= s1_next;
            for (int i = 0; i < LANES; i++)
            begin
                s2_reg[i] <= pmul(s1_reg[i], HP1);
                s4_reg[i] <= pmul(s3_reg[i], HP2);
                s6_reg[i] <= pmul(s5_reg[i], HP3);
            end
            s3_reg  <= s3_next;
            s5_reg  <= s5_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            s9_reg  <= s9_next;
            s10_reg <= pmul(s9_reg, HP2);
            s11_reg <= s11_next;
        end
    end

    // Remainder stages: shift in one hash bit, subtract the divisor if it fits.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        lane_t r_in, h_in, r_sh, r_next;
        logic  v_in;

        if (j == 0)
        begin : g_first
            assign r_in = '0;
            assign h_in = s11_reg;
            assign v_in = mv_reg[MIX_STAGES-1];
        end
        else
        begin : g_rest
            assign r_in = dr_reg[j-1];
            assign h_in = dh_reg[j-1];
            assign v_in = dv_reg[j-1];
        end

        assign r_sh   = {r_in[62:0], h_in[63-j]};
        assign r_next = (r_sh >= divisor) ? (r_sh - divisor) : r_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[j] <= r_next;
                dh_reg[j] <= h_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bucket_reg <= (size_reg == '0) ? '1 : dr_reg[DIV_STAGES-1];
        end
    end

    assign bucket_out.valid  = out_valid_reg;
    assign bucket_out.bucket = bucket_reg;

    // A zero table size always yields all ones.
    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && size_reg == '0) |-> (bucket_reg == '1))
        else $error("bucket not all ones for zero table size");

    // A nonzero table size yields a bucket below it.
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && size_reg != '0) |-> (bucket_reg < 64'(size_reg)))
        else $error("bucket out of range");

    // An accepted beat lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (key_in.valid && key_in.ready) |=> mv_reg[0])
        else $error("accepted beat lost at pipe entry");

    // A held output freezes the last remainder stage.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bucket_out.ready) |=> $stable(dv_reg[DIV_STAGES-1]))
        else $error("pipe advanced during stall");

endmodule
